// ===== rtl/utf8_code_point_decoder_top_macros.svh =====
// Assertion macros for the checker file of the UTF-8 decoder.
// Depends on nothing; each macro expects clk and arst_n in scope.
`ifndef UTF8_CODE_POINT_DECODER_TOP_MACROS_SVH
`define UTF8_CODE_POINT_DECODER_TOP_MACROS_SVH

// Same-cycle implication, idle during reset.
`define U8D_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, idle during reset.
`define U8D_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/utf8d_pkg.sv =====
// Types, constants and lead-byte decode for the UTF-8 code point decoder.
// No dependencies.
package utf8d_pkg;

	localparam int BYTE_W = 8;
	localparam int CP_W   = 31;
	localparam int CNT_W  = 3;
	localparam int DATA_W = 32;

	typedef logic [BYTE_W-1:0] byte_t;
	typedef logic [CP_W-1:0]   cp_t;
	typedef logic [CNT_W-1:0]  cnt_t;

	localparam cnt_t BAD_LEAD_LEFT = 3'd5;

	// One result item.
	typedef struct packed {
		logic is_error;
		cp_t  ucs_value;
	} res_t;

	// What a lead byte sets up.
	typedef struct packed {
		cnt_t left;
		cp_t  payload;
		logic bad;
	} lead_t;

	function automatic lead_t decode_lead(input byte_t b);
		lead_t l;
		l.bad = 1'b0;
		if ((b & 8'hE0) == 8'hC0) begin
			l.left    = 3'd1;
			l.payload = cp_t'(b & 8'h1F);
		end else if ((b & 8'hF0) == 8'hE0) begin
			l.left    = 3'd2;
			l.payload = cp_t'(b & 8'h0F);
		end else if ((b & 8'hF8) == 8'hF0) begin
			l.left    = 3'd3;
			l.payload = cp_t'(b & 8'h07);
		end else if ((b & 8'hFC) == 8'hF8) begin
			l.left    = 3'd4;
			l.payload = cp_t'(b & 8'h03);
		end else if ((b & 8'hFE) == 8'hFC) begin
			l.left    = 3'd5;
			l.payload = cp_t'(b & 8'h01);
		end else begin
			// continuation byte, 0xFE or 0xFF in lead position
			l.left    = BAD_LEAD_LEFT;
			l.payload = '0;
			l.bad     = 1'b1;
		end
		return l;
	endfunction

endpackage

// ===== rtl/utf8d_in_reg.sv =====
// Input register of the UTF-8 decoder: holds one byte until the decode stage takes it.
// Depends on utf8d_pkg.
module utf8d_in_reg
	import utf8d_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  logic  s_tvalid,
	output logic  s_tready,
	input  byte_t s_tdata,
	input  logic  take,
	output logic  valid_s1,
	output byte_t byte_s1
);

	assign s_tready = !valid_s1 || take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			byte_s1 <= s_tdata;
		end
	end

endmodule

// ===== rtl/utf8d_decode.sv =====
// Decode stage: sequence state and the per-byte step of the UTF-8 decoder.
// Depends on utf8d_pkg.
module utf8d_decode
	import utf8d_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  logic  valid_s1,
	input  byte_t byte_s1,
	input  logic  out_free,
	output logic  take,
	output logic  push,
	output res_t  res
);

	cnt_t  left_q;
	cp_t   partial_q;
	logic  bad_q;

	cnt_t  left_d;
	cp_t   partial_d;
	logic  bad_d;
	logic  emit;
	lead_t lead;
	cp_t   shifted;

	assign lead    = decode_lead(byte_s1);
	assign shifted = {partial_q[CP_W-7:0], byte_s1[5:0]};

	always_comb begin
		left_d        = left_q;
		partial_d     = partial_q;
		bad_d         = bad_q;
		emit          = 1'b0;
		res.is_error  = 1'b0;
		res.ucs_value = '0;
		if (left_q == '0) begin
			if (!byte_s1[BYTE_W-1]) begin
				emit          = 1'b1;
				res.ucs_value = cp_t'(byte_s1);
			end else begin
				left_d    = lead.left;
				partial_d = lead.payload;
				bad_d     = lead.bad;
			end
		end else begin
			left_d    = left_q - 3'd1;
			partial_d = shifted;
			if (left_q == 3'd1) begin
				emit          = 1'b1;
				res.is_error  = bad_q;
				res.ucs_value = bad_q ? '0 : shifted;
				partial_d     = '0;
				bad_d         = 1'b0;
			end
		end
	end

	// a byte that ends nothing never waits for the output
	assign take = valid_s1 && (out_free || !emit);
	assign push = take && emit;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			left_q    <= '0;
			partial_q <= '0;
			bad_q     <= 1'b0;
		end else if (take) begin
			left_q    <= left_d;
			partial_q <= partial_d;
			bad_q     <= bad_d;
		end
	end

endmodule

// ===== rtl/utf8d_out_reg.sv =====
// Result register of the UTF-8 decoder: holds one result until the sink takes it.
// Depends on utf8d_pkg.
module utf8d_out_reg
	import utf8d_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  res_t res,
	output logic out_free,
	output logic m_tvalid,
	input  logic m_tready,
	output res_t res_q
);

	assign out_free = !m_tvalid || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid <= 1'b0;
		end else if (out_free) begin
			m_tvalid <= push;
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			res_q <= res;
		end
	end

endmodule

// ===== rtl/utf8_code_point_decoder_top.sv =====
// Top level of the UTF-8 code point decoder (RFC 2279 form, up to six bytes).
// Depends on utf8d_pkg, utf8d_in_reg, utf8d_decode and utf8d_out_reg.
//
//   channel  | dir | handshake          | payload
//   ---------+-----+--------------------+---------------------------------------
//   s_*      | in  | s_tvalid/s_tready  | s_tdata[7:0] data_byte
//   m_*      | out | m_tvalid/m_tready  | m_tdata[30:0] ucs_value, [31] zero;
//            |     |                    | m_tuser[0] is_error
//
// One byte per cycle is taken unless a stall on m_tready backs up the input register.
// A byte that completes a code point is loaded into the input register at its
// transaction, then into the result register once that is free, and shows on m_*.
// Lead and middle bytes give no transaction on m_*.
// Reset clears the valid flags and the sequence state; a half-received
// sequence is dropped. A stall on m_tready holds the result register, and
// the input register keeps taking bytes that end no code point meanwhile.
module utf8_code_point_decoder_top
	import utf8d_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_tvalid,
	output logic              s_tready,
	input  logic [BYTE_W-1:0] s_tdata,  // [7:0] data_byte
	output logic              m_tvalid,
	input  logic              m_tready,
	output logic [DATA_W-1:0] m_tdata,  // [30:0] ucs_value, [31] zero fill
	output logic              m_tuser   // [0] is_error
);

	logic  valid_s1;
	byte_t byte_s1;
	logic  take;
	logic  push;
	logic  out_free;
	res_t  res;
	res_t  res_q;

	// hold the incoming byte
	utf8d_in_reg u_in (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.take     (take),
		.valid_s1 (valid_s1),
		.byte_s1  (byte_s1)
	);

	// advance the sequence state and form the result
	utf8d_decode u_dec (
		.clk      (clk),
		.arst_n   (arst_n),
		.valid_s1 (valid_s1),
		.byte_s1  (byte_s1),
		.out_free (out_free),
		.take     (take),
		.push     (push),
		.res      (res)
	);

	// hold the result until the sink takes it
	utf8d_out_reg u_out (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.res      (res),
		.out_free (out_free),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.res_q    (res_q)
	);

	assign m_tdata = {{(DATA_W-CP_W){1'b0}}, res_q.ucs_value};
	assign m_tuser = res_q.is_error;

endmodule

// ===== rtl/utf8d_checker.sv =====
// Port checker for the UTF-8 decoder top level, bound to it below.
// Depends on utf8d_pkg and utf8_code_point_decoder_top_macros.svh.
`include "utf8_code_point_decoder_top_macros.svh"

module utf8d_checker
	import utf8d_pkg::*;
(
	input logic              clk,
	input logic              arst_n,
	input logic              s_tvalid,
	input logic              s_tready,
	input logic [BYTE_W-1:0] s_tdata,
	input logic              m_tvalid,
	input logic              m_tready,
	input logic [DATA_W-1:0] m_tdata,
	input logic              m_tuser
);

	`U8D_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser), "stalled result changed")
	`U8D_ASSERT_NOW(a_err_zero, m_tvalid && m_tuser, m_tdata[CP_W-1:0] == '0, "error result carries a code point")
	`U8D_ASSERT_NOW(a_fill_zero, m_tvalid, m_tdata[DATA_W-1:CP_W] == '0, "fill bits of m_tdata not zero")
	`U8D_ASSERT_NOW(a_ready_empty, !m_tvalid, s_tready, "input stalled with empty result register")

endmodule

bind utf8_code_point_decoder_top utf8d_checker u_chk (.*);

// ===== tb/sv/utf8_code_point_decoder_top_test.sv =====
`timescale 1ns / 1ps
// Stream-level test of the UTF-8 code point decoder top: directed sequences, then random
// byte streams against a cycle-free decode model. Depends on utf8d_pkg and the RTL top.
module utf8_code_point_decoder_top_test;
	import utf8d_pkg::*;

	// Sizes of the random run and the points at which the pressure events start.
	localparam int RANDOM_BYTES = 1800;
	localparam int HOLD_AT      = 500;   // byte count at which the sink holds off
	localparam int HOLD_LEN     = 64;    // cycles of m_tready low during the hold-off
	localparam int PAUSE_AT     = 1100;  // byte count at which the source drains the block
	localparam int CALM_TAIL    = 200;   // last bytes sent with no idling on either side
	localparam int QUIET_LIMIT  = 2000;  // cycles with no transaction before giving up
	localparam int DRAIN_CYCLES = 8;     // settle time after the last expected result

	logic              clk      = 1'b0;
	logic              arst_n   = 1'b0;
	logic              s_tvalid = 1'b0;
	logic              s_tready;
	logic [BYTE_W-1:0] s_tdata  = '0;    // [7:0] data_byte
	logic              m_tvalid;
	logic              m_tready = 1'b0;
	logic [DATA_W-1:0] m_tdata;          // [30:0] ucs_value, [31] zero fill
	logic              m_tuser;          // [0] is_error

	// Bytes still to be offered, and code points still to be seen on m_*.
	byte_t byte_queue[$];
	res_t  expected_points[$];

	// Decode state of the model, advanced once per accepted input transaction.
	cnt_t seq_left  = '0;
	cp_t  seq_value = '0;
	logic seq_bad   = 1'b0;

	int   bytes_in     = 0;
	int   total_bytes  = 0;
	int   mismatches   = 0;
	int   quiet_cycles = 0;
	logic byte_taken   = 1'b0;

	// Source-side and sink-side idling.
	int   send_gap   = 0;
	int   sink_gap   = 0;
	int   hold_left  = 0;
	logic hold_done  = 1'b0;
	logic pause_done = 1'b0;

	wire holding = (hold_left != 0);
	wire calm    = (bytes_in >= total_bytes - CALM_TAIL);

	utf8_code_point_decoder_top dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	initial begin
		forever #1 clk = ~clk;
	end

	task automatic flag_mismatch(input string what, input logic [DATA_W-1:0] got,
			input logic [DATA_W-1:0] want);
		$display("%0t: mismatch on %s: got %0h, want %0h", $time, what, got, want);
		mismatches++;
	endtask

	// Advance the decode model by one byte and queue the code point it completes, if any.
	task automatic decode_byte(input byte_t b);
		res_t r;
		if (seq_left == 0) begin
			if (b < 8'h80) begin
				r.is_error  = 1'b0;
				r.ucs_value = cp_t'(b);
				expected_points.push_back(r);
			end else begin
				seq_bad = 1'b0;
				if ((b & 8'hE0) == 8'hC0) begin
					seq_left  = 3'd1;
					seq_value = cp_t'(b & 8'h1F);
				end else if ((b & 8'hF0) == 8'hE0) begin
					seq_left  = 3'd2;
					seq_value = cp_t'(b & 8'h0F);
				end else if ((b & 8'hF8) == 8'hF0) begin
					seq_left  = 3'd3;
					seq_value = cp_t'(b & 8'h07);
				end else if ((b & 8'hFC) == 8'hF8) begin
					seq_left  = 3'd4;
					seq_value = cp_t'(b & 8'h03);
				end else if ((b & 8'hFE) == 8'hFC) begin
					seq_left  = 3'd5;
					seq_value = cp_t'(b & 8'h01);
				end else begin
					// stray continuation, 0xFE or 0xFF: swallow five bytes, then flag
					seq_left  = BAD_LEAD_LEFT;
					seq_value = '0;
					seq_bad   = 1'b1;
				end
			end
		end else begin
			// the 10xxxxxx pattern is not checked; keep only the low six bits
			seq_value = {seq_value[CP_W-7:0], b[5:0]};
			seq_left  = seq_left - 3'd1;
			if (seq_left == 0) begin
				r.is_error  = seq_bad;
				r.ucs_value = seq_bad ? '0 : seq_value;
				expected_points.push_back(r);
				seq_bad   = 1'b0;
				seq_value = '0;
			end
		end
	endtask

	// Sample both handshakes at the rising edge: check results first, then feed the model.
	always @(posedge clk) begin : result_monitor
		res_t want;
		if (arst_n) begin
			byte_taken <= s_tvalid && s_tready;
			if (m_tvalid && m_tready) begin
				if (expected_points.size() == 0) begin
					flag_mismatch("unexpected result", m_tdata, '0);
				end else begin
					want = expected_points.pop_front();
					if (m_tdata[CP_W-1:0] != want.ucs_value)
						flag_mismatch("ucs_value", DATA_W'(m_tdata[CP_W-1:0]),
							DATA_W'(want.ucs_value));
					if (m_tuser != want.is_error)
						flag_mismatch("is_error", DATA_W'(m_tuser), DATA_W'(want.is_error));
					if (m_tdata[DATA_W-1:CP_W] != '0)
						flag_mismatch("tdata fill", DATA_W'(m_tdata[DATA_W-1:CP_W]), '0);
				end
			end
			if (s_tvalid && s_tready) begin
				decode_byte(s_tdata);
				bytes_in <= bytes_in + 1;
			end
		end
	end

	// Source: hold the offered byte until its transaction, then idle, pause or advance.
	always @(negedge clk) begin : byte_driver
		if (arst_n && (!s_tvalid || byte_taken)) begin
			if (!pause_done && bytes_in >= PAUSE_AT) begin
				// drain the block completely before sending on
				s_tvalid <= 1'b0;
				if (expected_points.size() == 0)
					pause_done <= 1'b1;
			end else if (send_gap != 0) begin
				s_tvalid <= 1'b0;
				send_gap <= send_gap - 1;
			end else if (byte_queue.size() != 0) begin
				s_tdata  <= byte_queue.pop_front();
				s_tvalid <= 1'b1;
				// keep offering during the sink hold-off so the block backs up
				if (!calm && !holding && $urandom_range(0, 3) == 0)
					send_gap <= $urandom_range(1, 3);
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	// Sink: short random stalls, and one long hold-off counted here.
	always @(negedge clk) begin : result_sink
		if (arst_n) begin
			if (hold_left != 0) begin
				m_tready  <= 1'b0;
				hold_left <= hold_left - 1;
			end else if (!hold_done && bytes_in >= HOLD_AT) begin
				m_tready  <= 1'b0;
				hold_left <= HOLD_LEN - 1;
				hold_done <= 1'b1;
			end else if (sink_gap != 0) begin
				m_tready <= 1'b0;
				sink_gap <= sink_gap - 1;
			end else if (!calm && $urandom_range(0, 3) == 0) begin
				m_tready <= 1'b0;
				sink_gap <= $urandom_range(0, 2);
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	// Drop the run if neither side moves a transaction for too long.
	always @(posedge clk) begin : watchdog
		if (arst_n) begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
				quiet_cycles <= 0;
			end else if (quiet_cycles >= QUIET_LIMIT) begin
				$display("utf8_code_point_decoder_top_test NOT OK");
				$finish;
			end else begin
				quiet_cycles <= quiet_cycles + 1;
			end
		end
	end

	initial begin : stimulus
		int    pick;
		int    len;
		byte_t lead;
		// Directed part: ASCII extremes, the largest two-byte value with a malformed
		// trailer, minimum three-byte, maximum four-byte, minimum five-byte, maximum
		// six-byte, and a 0xFE lead followed by the five bytes that it swallows.
		byte_queue = '{8'h00, 8'h7F,
			8'hDF, 8'h7F,
			8'hE0, 8'h80, 8'h80,
			8'hF7, 8'hBF, 8'hBF, 8'hBF,
			8'hF8, 8'h80, 8'h80, 8'h80, 8'h80,
			8'hFD, 8'hBF, 8'hBF, 8'hBF, 8'hBF, 8'hBF,
			8'hFE, 8'hFF, 8'h00, 8'hC0, 8'h7F, 8'h80};

		// Random part: mostly well-formed sequences, some bad leads and raw noise.
		while (byte_queue.size() < RANDOM_BYTES + 28) begin
			pick = $urandom_range(0, 99);
			if (pick < 15) begin
				byte_queue.push_back(byte_t'($urandom_range(0, 8'h7F)));
			end else if (pick < 70) begin
				len = $urandom_range(2, 6);
				case (len)
					2:       lead = 8'hC0 | byte_t'($urandom_range(0, 8'h1F));
					3:       lead = 8'hE0 | byte_t'($urandom_range(0, 8'h0F));
					4:       lead = 8'hF0 | byte_t'($urandom_range(0, 8'h07));
					5:       lead = 8'hF8 | byte_t'($urandom_range(0, 8'h03));
					default: lead = 8'hFC | byte_t'($urandom_range(0, 8'h01));
				endcase
				byte_queue.push_back(lead);
				repeat (len - 1)
					byte_queue.push_back(8'h80 | byte_t'($urandom_range(0, 8'h3F)));
			end else if (pick < 80) begin
				case ($urandom_range(0, 2))
					0:       lead = 8'hFE;
					1:       lead = 8'hFF;
					default: lead = byte_t'($urandom_range(8'h80, 8'hBF));
				endcase
				byte_queue.push_back(lead);
				repeat (5)
					byte_queue.push_back(byte_t'($urandom_range(0, 8'hFF)));
			end else begin
				byte_queue.push_back(byte_t'($urandom_range(0, 8'hFF)));
			end
		end
		total_bytes = byte_queue.size();

		// Hold reset, then release it away from the rising edge.
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Wait for every byte and every expected code point, then let the pipe settle.
		while (bytes_in != total_bytes || expected_points.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (mismatches == 0) begin
			$display("utf8_code_point_decoder_top_test OK");
		end else begin
			$display("utf8_code_point_decoder_top_test NOT OK");
		end
		$finish;
	end

endmodule
